### src/c39_pkg.sv
package c39_pkg;

  localparam logic [5:0] FRAME_VALUE = 6'd43;
  localparam int unsigned MOD_BASE = 43;

  localparam logic CFG_EXTENDED_MODE = 1'b0;
  localparam logic CFG_CHECKSUM_ENABLE = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic [1:0] cnt;
    logic [5:0] a;
    logic [5:0] b;
  } dec_t;

  typedef struct packed {
    logic [8:0] pattern;
    logic [5:0] value;
    logic       gap;
    logic       err;
    logic       last;
  } res_t;

  // Element widths, first bar in bit 8, 1 = wide.
  function automatic logic [8:0] pattern_of(input logic [5:0] v);
    logic [8:0] p;
    case (v)
      6'd0:  p = 9'b000110100;
      6'd1:  p = 9'b100100001;
      6'd2:  p = 9'b001100001;
      6'd3:  p = 9'b101100000;
      6'd4:  p = 9'b000110001;
      6'd5:  p = 9'b100110000;
      6'd6:  p = 9'b001110000;
      6'd7:  p = 9'b000100101;
      6'd8:  p = 9'b100100100;
      6'd9:  p = 9'b001100100;
      6'd10: p = 9'b100001001;
      6'd11: p = 9'b001001001;
      6'd12: p = 9'b101001000;
      6'd13: p = 9'b000011001;
      6'd14: p = 9'b100011000;
      6'd15: p = 9'b001011000;
      6'd16: p = 9'b000001101;
      6'd17: p = 9'b100001100;
      6'd18: p = 9'b001001100;
      6'd19: p = 9'b000011100;
      6'd20: p = 9'b100000011;
      6'd21: p = 9'b001000011;
      6'd22: p = 9'b101000010;
      6'd23: p = 9'b000010011;
      6'd24: p = 9'b100010010;
      6'd25: p = 9'b001010010;
      6'd26: p = 9'b000000111;
      6'd27: p = 9'b100000110;
      6'd28: p = 9'b001000110;
      6'd29: p = 9'b000010110;
      6'd30: p = 9'b110000001;
      6'd31: p = 9'b011000001;
      6'd32: p = 9'b111000000;
      6'd33: p = 9'b010010001;
      6'd34: p = 9'b110010000;
      6'd35: p = 9'b011010000;
      6'd36: p = 9'b010000101;
      6'd37: p = 9'b110000100;
      6'd38: p = 9'b011000100;
      6'd39: p = 9'b010101000;
      6'd40: p = 9'b010100010;
      6'd41: p = 9'b010001010;
      6'd42: p = 9'b000101010;
      default: p = 9'b010010100; // start/stop frame
    endcase
    return p;
  endfunction

  function automatic logic [5:0] add_mod43(input logic [5:0] x, input logic [5:0] y);
    logic [6:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= 7'(MOD_BASE)) begin
      s = s - 7'(MOD_BASE);
    end
    return s[5:0];
  endfunction

  function automatic dec_t basic_decode(input logic [7:0] c_in);
    logic [7:0] c;
    logic [7:0] t;
    dec_t d;
    c = c_in;
    t = 8'd0;
    d = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - 8'd32;
    end
    d.cnt = 2'd1;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'd48;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'd55;
    end else begin
      case (c)
        8'h2d:   t = 8'd36;
        8'h2e:   t = 8'd37;
        8'h20:   t = 8'd38;
        8'h24:   t = 8'd39;
        8'h2f:   t = 8'd40;
        8'h2b:   t = 8'd41;
        8'h25:   t = 8'd42;
        default: d.cnt = 2'd0;
      endcase
    end
    d.a = t[5:0];
    return d;
  endfunction

  // Full ASCII: shift symbol in a, shifted letter in b when two symbols.
  function automatic dec_t ext_decode(input logic [7:0] c);
    logic [7:0] t;
    dec_t d;
    d = '0;
    t = 8'd0;
    d.cnt = 2'd2;
    if (c > 8'd127) begin
      d.cnt = 2'd0;
    end else if (c == 8'd0) begin
      d.a = 6'd42; t = 8'd30;
    end else if (c <= 8'd26) begin
      d.a = 6'd39; t = c + 8'd9;
    end else if (c <= 8'd31) begin
      d.a = 6'd42; t = c - 8'd17;
    end else if (c == 8'd32) begin
      d.cnt = 2'd1; d.a = 6'd38;
    end else if (c <= 8'd44) begin
      d.a = 6'd40; t = c - 8'd23;
    end else if (c == 8'd45) begin
      d.cnt = 2'd1; d.a = 6'd36;
    end else if (c == 8'd46) begin
      d.cnt = 2'd1; d.a = 6'd37;
    end else if (c == 8'd47) begin
      d.a = 6'd40; t = 8'd24;
    end else if (c <= 8'd57) begin
      d.cnt = 2'd1; t = c - 8'd48; d.a = t[5:0];
    end else if (c == 8'd58) begin
      d.a = 6'd40; t = 8'd35;
    end else if (c <= 8'd63) begin
      d.a = 6'd42; t = c - 8'd44;
    end else if (c == 8'd64) begin
      d.a = 6'd42; t = 8'd31;
    end else if (c <= 8'd90) begin
      d.cnt = 2'd1; t = c - 8'd55; d.a = t[5:0];
    end else if (c <= 8'd95) begin
      d.a = 6'd42; t = c - 8'd71;
    end else if (c == 8'd96) begin
      d.a = 6'd42; t = 8'd32;
    end else if (c <= 8'd122) begin
      d.a = 6'd41; t = c - 8'd87;
    end else begin
      d.a = 6'd42; t = c - 8'd98;
    end
    if (d.cnt == 2'd2) begin
      d.b = t[5:0];
    end
    return d;
  endfunction

endpackage

### src/code39_symbol_encoder.sv
// Code 39 symbol encoder.
// Latency: first result is valid the cycle after its item is accepted.
// Throughput: one result per cycle while out_tready is high. An item yields
//   up to 3 results (start + shift + letter), an end item up to 2 (check +
//   stop); the next item is taken as the last buffered result leaves.
// Reset (synchronous, rst_n low): config registers, message state and result
//   count clear, so no result is pending; the buffered results are not reset.
module code39_symbol_encoder
  import c39_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] pattern, [14:9] symbol_value,
                                  // [15] gap_after, [16] error, [23:17] zero
  output logic        out_tlast
);

  logic       ext_mode_r, chk_en_r;
  logic       started_r, started_nxt;
  logic       failed_r, failed_nxt;
  logic [5:0] sum_r, sum_nxt;
  res_t       slot_r [3];
  res_t       slot_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;
  res_t       cur;
  dec_t       dec;
  logic [5:0] sum_a;
  logic       in_acc, out_acc;

  function automatic res_t sym(input logic [5:0] v, input logic gap, input logic last);
    res_t r;
    r.pattern = pattern_of(v);
    r.value = v;
    r.gap = gap;
    r.err = 1'b0;
    r.last = last;
    return r;
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign out_tvalid = (idx_r != cnt_r);
  // buffer free now, or its final result leaves this cycle
  assign in_tready = (idx_r == cnt_r) || (out_acc && (idx_r + 2'd1 == cnt_r));

  always_comb begin
    case (idx_r)
      2'd1:    cur = slot_r[1];
      2'd2:    cur = slot_r[2];
      default: cur = slot_r[0];
    endcase
  end

  assign out_tdata = {7'd0, cur.err, cur.gap, cur.value, cur.pattern};
  assign out_tlast = cur.last;

  always_comb begin
    dec = ext_mode_r ? ext_decode(in_tdata) : basic_decode(in_tdata);
    sum_a = add_mod43(sum_r, dec.a);
    started_nxt = started_r;
    failed_nxt = failed_r;
    sum_nxt = sum_r;
    cnt_nxt = 2'd0;
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    slot_nxt[2] = slot_r[2];
    if (in_tuser == KIND_END) begin
      started_nxt = 1'b0;
      failed_nxt = 1'b0;
      sum_nxt = 6'd0;
      if (failed_r || !started_r) begin
        slot_nxt[0] = '{pattern: 9'd0, value: 6'd0, gap: 1'b0, err: 1'b1, last: 1'b1};
        cnt_nxt = 2'd1;
      end else if (chk_en_r) begin
        slot_nxt[0] = sym(sum_r, 1'b1, 1'b0);
        slot_nxt[1] = sym(FRAME_VALUE, 1'b0, 1'b1);
        cnt_nxt = 2'd2;
      end else begin
        slot_nxt[0] = sym(FRAME_VALUE, 1'b0, 1'b1);
        cnt_nxt = 2'd1;
      end
    end else if (!failed_r) begin
      if (dec.cnt == 2'd0) begin
        failed_nxt = 1'b1;
      end else begin
        started_nxt = 1'b1;
        sum_nxt = (dec.cnt == 2'd2) ? add_mod43(sum_a, dec.b) : sum_a;
        if (!started_r) begin
          slot_nxt[0] = sym(FRAME_VALUE, 1'b1, 1'b0);
          slot_nxt[1] = sym(dec.a, 1'b1, 1'b0);
          slot_nxt[2] = sym(dec.b, 1'b1, 1'b0);
          cnt_nxt = dec.cnt + 2'd1;
        end else begin
          slot_nxt[0] = sym(dec.a, 1'b1, 1'b0);
          slot_nxt[1] = sym(dec.b, 1'b1, 1'b0);
          cnt_nxt = dec.cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r <= 1'b0;
      chk_en_r <= 1'b0;
      started_r <= 1'b0;
      failed_r <= 1'b0;
      sum_r <= 6'd0;
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_EXTENDED_MODE) begin
          ext_mode_r <= cfg_wdata;
        end else begin
          chk_en_r <= cfg_wdata;
        end
      end
      if (in_acc) begin
        started_r <= started_nxt;
        failed_r <= failed_nxt;
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        idx_r <= 2'd0;
      end else if (out_acc) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r[0] <= slot_nxt[0];
      slot_r[1] <= slot_nxt[1];
      slot_r[2] <= slot_nxt[2];
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r) else $error("result index past buffer fill");

  a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlast |-> (idx_r + 2'd1 == cnt_r))
    else $error("last result not at end of buffered group");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stalled input with empty buffer");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tlast && !out_tdata[15])
    else $error("error result not marked last");
`endif

endmodule

### bench/tb_code39_symbol_encoder.sv
`default_nettype none

module tb_code39_symbol_encoder;
  import c39_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Nine element widths per symbol, values 0..42 then the start/stop frame.
  localparam int N_BAR_CHARS = 44 * 9;
  localparam bit [8*N_BAR_CHARS-1:0] BAR_WIDTHS = {
    "NnNwWnWnN", "WnNwNnNnW", "NnWwNnNnW", "WnWwNnNnN", "NnNwWnNnW",
    "WnNwWnNnN", "NnWwWnNnN", "NnNwNnWnW", "WnNwNnWnN", "NnWwNnWnN",
    "WnNnNwNnW", "NnWnNwNnW", "WnWnNwNnN", "NnNnWwNnW", "WnNnWwNnN",
    "NnWnWwNnN", "NnNnNwWnW", "WnNnNwWnN", "NnWnNwWnN", "NnNnWwWnN",
    "WnNnNnNwW", "NnWnNnNwW", "WnWnNnNwN", "NnNnWnNwW", "WnNnWnNwN",
    "NnWnWnNwN", "NnNnNnWwW", "WnNnNnWwN", "NnWnNnWwN", "NnNnWnWwN",
    "WwNnNnNnW", "NwWnNnNnW", "WwWnNnNnN", "NwNnWnNnW", "WwNnWnNnN",
    "NwWnWnNnN", "NwNnNnWnW", "WwNnNnWnN", "NwWnNnWnN", "NwNwNwNnN",
    "NwNwNnNwN", "NwNnNwNwN", "NnNwNwNwN", "NwNnWnWnN"};
  localparam bit [8*43-1:0] ALPHABET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] char_code
  logic        in_tuser   = 1'b0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [8:0] pattern, [14:9] symbol_value,
                                    // [15] gap_after, [16] error, [23:17] zero
  logic        out_tlast;

  code39_symbol_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // predictor state
  bit         ext_mode;
  bit         chk_en;
  bit         msg_open;
  bit         msg_bad;
  logic [5:0] sum_mod43;
  res_t       expected_symbols[$];

  int mismatches  = 0;
  int tx_idle_pct = 6;
  int rx_idle_pct = 66;
  int rx_hold     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random ready, or ready held low while rx_hold counts down
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [8:0] wide_pattern(input logic [5:0] v);
    logic [8:0] p;
    logic [7:0] ch;
    int base;
    base = ((v > FRAME_VALUE) ? 43 : int'(v)) * 9;
    p = '0;
    for (int k = 0; k < 9; k++) begin
      ch = BAR_WIDTHS[8*(N_BAR_CHARS-1-base-k) +: 8];
      p = {p[7:0], (ch == "W" || ch == "w")};
    end
    return p;
  endfunction

  // Returns the number of symbols for one byte, 0 when it is not encodable.
  function automatic int map_char(input logic [7:0] c, input bit ext,
                                  output logic [5:0] s0, output logic [5:0] s1);
    int u;
    u = int'(c);
    s0 = '0;
    s1 = '0;
    if (!ext) begin
      if (u >= "a" && u <= "z") u = u - 32;
      if (u >= "0" && u <= "9") s0 = 6'(u - 48);
      else if (u >= "A" && u <= "Z") s0 = 6'(u - 55);
      else begin
        case (u)
          "-":     s0 = 6'd36;
          ".":     s0 = 6'd37;
          " ":     s0 = 6'd38;
          "$":     s0 = 6'd39;
          "/":     s0 = 6'd40;
          "+":     s0 = 6'd41;
          "%":     s0 = 6'd42;
          default: return 0;
        endcase
      end
      return 1;
    end
    if (u > 127) return 0;
    if (u == 0) begin s0 = 6'd42; s1 = 6'd30; end
    else if (u <= 26) begin s0 = 6'd39; s1 = 6'(u + 9); end
    else if (u <= 31) begin s0 = 6'd42; s1 = 6'(u - 17); end
    else if (u == 32) begin s0 = 6'd38; return 1; end
    else if (u <= 44) begin s0 = 6'd40; s1 = 6'(u - 23); end
    else if (u == 45) begin s0 = 6'd36; return 1; end
    else if (u == 46) begin s0 = 6'd37; return 1; end
    else if (u == 47) begin s0 = 6'd40; s1 = 6'd24; end
    else if (u <= 57) begin s0 = 6'(u - 48); return 1; end
    else if (u == 58) begin s0 = 6'd40; s1 = 6'd35; end
    else if (u <= 63) begin s0 = 6'd42; s1 = 6'(u - 44); end
    else if (u == 64) begin s0 = 6'd42; s1 = 6'd31; end
    else if (u <= 90) begin s0 = 6'(u - 55); return 1; end
    else if (u <= 95) begin s0 = 6'd42; s1 = 6'(u - 71); end
    else if (u == 96) begin s0 = 6'd42; s1 = 6'd32; end
    else if (u <= 122) begin s0 = 6'd41; s1 = 6'(u - 87); end
    else begin s0 = 6'd42; s1 = 6'(u - 98); end
    return 2;
  endfunction

  task automatic push_symbol(input logic [5:0] v, input bit gap, input bit err,
                             input bit last);
    res_t r;
    r.pattern = err ? 9'd0 : wide_pattern(v);
    r.value   = err ? 6'd0 : v;
    r.gap     = gap;
    r.err     = err;
    r.last    = last;
    expected_symbols.push_back(r);
  endtask

  task automatic encode_item(input logic kind, input logic [7:0] c);
    logic [5:0] sym[2];
    int n;
    if (kind == KIND_END) begin
      if (msg_bad || !msg_open) begin
        push_symbol(6'd0, 1'b0, 1'b1, 1'b1);
      end else begin
        if (chk_en) push_symbol(sum_mod43, 1'b1, 1'b0, 1'b0);
        push_symbol(FRAME_VALUE, 1'b0, 1'b0, 1'b1);
      end
      msg_open  = 1'b0;
      msg_bad   = 1'b0;
      sum_mod43 = '0;
    end else if (!msg_bad) begin
      n = map_char(c, ext_mode, sym[0], sym[1]);
      if (n == 0) begin
        msg_bad = 1'b1;
      end else begin
        if (!msg_open) push_symbol(FRAME_VALUE, 1'b1, 1'b0, 1'b0);
        msg_open = 1'b1;
        for (int k = 0; k < n; k++) begin
          push_symbol(sym[k], 1'b1, 1'b0, 1'b0);
          sum_mod43 = 6'((int'(sum_mod43) + int'(sym[k])) % 43);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch("unexpected symbol, pattern", int'(out_tdata[8:0]), -1);
      end else begin
        want = expected_symbols.pop_front();
        if (out_tdata[8:0] !== want.pattern)
          report_mismatch("pattern", int'(out_tdata[8:0]), int'(want.pattern));
        if (out_tdata[14:9] !== want.value)
          report_mismatch("symbol_value", int'(out_tdata[14:9]), int'(want.value));
        if (out_tdata[15] !== want.gap)
          report_mismatch("gap_after", int'(out_tdata[15]), int'(want.gap));
        if (out_tdata[16] !== want.err)
          report_mismatch("error", int'(out_tdata[16]), int'(want.err));
        if (out_tlast !== want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
      end
    end
  end

  // valid stays high between back-to-back items; it is only lowered on idle
  task automatic send_item(input logic kind, input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    encode_item(kind, c);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input bit ext, input bit chk);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_EXTENDED_MODE;
    cfg_wdata <= ext;
    @(posedge clk);
    ext_mode = ext;
    cfg_index <= CFG_CHECKSUM_ENABLE;
    cfg_wdata <= chk;
    @(posedge clk);
    chk_en = chk;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_message(input string s);
    for (int k = 0; k < s.len(); k++) send_item(KIND_CHAR, s[k]);
    send_item(KIND_END, 8'd0);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'($urandom_range(255));
    if (ext_mode) return 8'($urandom_range(127));
    if (r < 20) return 8'("a" + $urandom_range(25));
    return ALPHABET[8*(42 - $urandom_range(42)) +: 8];
  endfunction

  task automatic send_random_messages(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_item(KIND_CHAR, pick_char());
      // char_code is don't-care on the end item
      send_item(KIND_END, 8'($urandom_range(255)));
      sent += len + 1;
    end
  endtask

  task automatic test_basic_symbols();
    write_regs(1'b0, 1'b1);
    send_message("-. $/+%");
    send_message("Az9");
  endtask

  task automatic test_bad_messages();
    send_item(KIND_END, 8'd0);     // empty message
    send_item(KIND_CHAR, 8'hff);   // invalid, then a char after the failure
    send_item(KIND_CHAR, "A");
    send_item(KIND_END, 8'hff);
  endtask

  task automatic test_extended_map();
    write_regs(1'b1, 1'b0);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'h7f);
    send_item(KIND_CHAR, 8'h20);
    send_item(KIND_CHAR, 8'h41);
    send_item(KIND_CHAR, 8'h61);
    send_item(KIND_CHAR, 8'h3a);
    send_item(KIND_END, 8'h00);
    send_item(KIND_CHAR, 8'h80);   // above 127 is invalid here
    send_item(KIND_END, 8'h00);
  endtask

  task automatic test_random_basic();
    write_regs(1'b0, 1'b0);
    send_random_messages(60);
    write_regs(1'b0, 1'b1);
    send_random_messages(60);
  endtask

  task automatic test_random_extended();
    write_regs(1'b1, 1'b1);
    send_random_messages(60);
    write_regs(1'b1, 1'b0);
    send_random_messages(60);
  endtask

  task automatic test_random_no_idle();
    write_regs(1'b1, 1'b1);
    send_random_messages(50);
    write_regs(1'b0, 1'b1);
    send_random_messages(40);
  endtask

  // long output hold-off while lower-case letters (two symbols each) keep coming
  task automatic test_output_stall();
    write_regs(1'b1, 1'b1);
    rx_hold = 300;
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 4; k++) send_item(KIND_CHAR, 8'("a" + $urandom_range(25)));
      send_item(KIND_END, 8'd0);
    end
    wait_idle();
  endtask

  initial begin
    ext_mode  = 1'b0;
    chk_en    = 1'b0;
    msg_open  = 1'b0;
    msg_bad   = 1'b0;
    sum_mod43 = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_symbols();
    test_bad_messages();
    test_extended_map();
    test_random_basic();
    tx_idle_pct = 66;
    rx_idle_pct = 6;
    test_random_extended();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_no_idle();

    wait_idle();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
